FILE: src/mtbg_pkg.sv
// ----------------------------------------------------------------------------
// mtbg_pkg
// Shared types and constants for the MT19937 bounded generator.
// ----------------------------------------------------------------------------
`default_nettype none
package mtbg_pkg;
    localparam int STATE_WORDS = 624;
    localparam int MID_OFFSET  = 397;
    localparam int IDX_W       = 10;
    localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
    localparam logic [31:0] SEED_MULT    = 32'd1812433253;
    localparam logic [31:0] DEFAULT_SEED = 32'd5489;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc60000;

    localparam logic CMD_SEED = 1'b0;
    localparam logic CMD_DRAW = 1'b1;
    localparam logic       REG_USE_BOUND   = 1'b0;
    localparam logic       REG_BOUND_RANGE = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE, S_SEED_RD, S_SEED_W0, S_SEED_MUL, S_SEED_WR,
        S_TW_RD0, S_TW_RD1, S_TW_RD2, S_TW_LATCH, S_TW_WR,
        S_DR_RD, S_DR_WAIT, S_DR_TEMP, S_DR_MUL, S_DR_CHK,
        S_MOD_RUN, S_DR_CHK2, S_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic       load_seed;   // capture seed into prev register
        logic       use_default; // seed from default constant
        logic       seed_w0;     // write word 0 from prev
        logic       seed_mul;    // compute next seed word into prev
        logic       seed_wr;     // write prev at counter
        logic       cnt_clr;
        logic       cnt_inc;
        logic [1:0] rd_sel;      // 0: cnt, 1: cnt+1, 2: cnt+397, 3: word index
        logic       tw_cap_k;
        logic       tw_cap_n;
        logic       tw_cap_f;
        logic       tw_wr;
        logic       dr_cap;      // capture read word and temper
        logic       mul;         // start product
        logic       mod_start;
        logic       idx_seeded;  // set index to 624
        logic       idx_zero;
        logic       idx_inc;
        logic       out_load;
        logic       out_bounded;
    } t_cmd;

    typedef struct packed {
        logic cnt_last;    // counter at last word
        logic idx_empty;   // index >= 624
        logic never_seeded;
        logic range_zero;
        logic lo_below_range;
        logic lo_below_t;
        logic mod_done;
        logic out_busy;
    } t_status;
endpackage
`default_nettype wire

FILE: src/mtbg_if.sv
// ----------------------------------------------------------------------------
// mtbg_if
// Valid/ready stream channel carrying a generic payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface mtbg_if #(parameter int W = 33);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/mtbg_ram.sv
// ----------------------------------------------------------------------------
// mtbg_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module mtbg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

FILE: src/mtbg_mod.sv
// ----------------------------------------------------------------------------
// mtbg_mod
// Restoring divider remainder unit: (2^32 - r) mod r, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module mtbg_mod (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_range,
    output logic             o_done,
    output logic      [31:0] o_rem
);
    logic [31:0] r_num, n_num;
    logic [32:0] r_rem, n_rem;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [32:0] w_sh;

    always_comb begin
        n_num = r_num; n_rem = r_rem; n_cnt = r_cnt; n_busy = r_busy;
        w_sh = {r_rem[31:0], r_num[31]};
        if (i_start) begin
            n_num = 32'd0 - i_range;
            n_rem = '0; n_cnt = 6'd32; n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[30:0], 1'b0};
            n_rem = (w_sh >= {1'b0, i_range}) ? w_sh - {1'b0, i_range} : w_sh;
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_cnt <= n_cnt;
        end
        r_num <= n_num; r_rem <= n_rem;
    end
    assign o_done = !r_busy;
    assign o_rem  = r_rem[31:0];
endmodule
`default_nettype wire

FILE: src/mtbg_datapath.sv
// ----------------------------------------------------------------------------
// mtbg_datapath
// State memory, seed/twist/temper arithmetic, bounded multiply and output.
// ----------------------------------------------------------------------------
`default_nettype none
module mtbg_datapath #(
    parameter int STATE_WORDS = mtbg_pkg::STATE_WORDS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mtbg_pkg::t_cmd    i_cmd,
    input  wire logic [31:0]       i_seed,
    input  wire logic              i_use_bound,
    input  wire logic [31:0]       i_range,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic      [31:0]       o_out_value,
    output mtbg_pkg::t_status      o_status
);
    localparam int AW = $clog2(STATE_WORDS);
    localparam int IW = mtbg_pkg::IDX_W;
    localparam logic [AW-1:0] LAST = AW'(STATE_WORDS - 1);

    logic [AW-1:0] r_cnt;
    logic [IW-1:0] r_idx;
    logic [31:0]   r_prev, r_k, r_n, r_f, r_temp, r_res;
    logic [63:0]   r_prod;
    logic          r_out_valid;
    logic [AW-1:0] w_addr;
    logic [31:0]   w_wdata, w_rdata, w_y, w_tw, w_t1, w_t2, w_t3;
    logic          w_we;
    logic [31:0]   w_mod_rem;
    logic          w_mod_done;

    function automatic logic [AW-1:0] wrap(input logic [AW:0] a);
        return (a >= (AW+1)'(STATE_WORDS)) ? AW'(a - (AW+1)'(STATE_WORDS)) : a[AW-1:0];
    endfunction

    always_comb begin
        unique case (i_cmd.rd_sel)
            2'd0: w_addr = r_cnt;
            2'd1: w_addr = wrap({1'b0, r_cnt} + (AW+1)'(1));
            2'd2: w_addr = wrap({1'b0, r_cnt} + (AW+1)'(mtbg_pkg::MID_OFFSET));
            default: w_addr = r_idx[AW-1:0];
        endcase
        w_y  = {r_k[31], r_n[30:0]};
        w_tw = r_f ^ (w_y >> 1) ^ (w_y[0] ? mtbg_pkg::TWIST_MATRIX : 32'd0);
        w_we = i_cmd.seed_w0 | i_cmd.seed_wr | i_cmd.tw_wr;
        w_wdata = i_cmd.tw_wr ? w_tw : r_prev;
        w_t1 = w_rdata ^ (w_rdata >> 11);
        w_t2 = w_t1 ^ ((w_t1 << 7) & mtbg_pkg::TEMPER_B);
        w_t3 = w_t2 ^ ((w_t2 << 15) & mtbg_pkg::TEMPER_C);
    end

    mtbg_ram #(.WIDTH(32), .DEPTH(STATE_WORDS)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(w_wdata), .o_rdata(w_rdata)
    );

    mtbg_mod u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.mod_start),
        .i_range(i_range), .o_done(w_mod_done), .o_rem(w_mod_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= IW'(STATE_WORDS + 1);
            r_out_valid <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.cnt_clr) r_cnt <= '0;
            else if (i_cmd.cnt_inc) r_cnt <= r_cnt + AW'(1);
            if (i_cmd.idx_seeded) r_idx <= IW'(STATE_WORDS);
            else if (i_cmd.idx_zero) r_idx <= '0;
            else if (i_cmd.idx_inc) r_idx <= r_idx + IW'(1);
            if (i_cmd.out_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
        // seed word i is built while the counter holds i
        if (i_cmd.load_seed)
            r_prev <= i_cmd.use_default ? mtbg_pkg::DEFAULT_SEED : i_seed;
        else if (i_cmd.seed_mul)
            r_prev <= mtbg_pkg::SEED_MULT * (r_prev ^ (r_prev >> 30))
                      + 32'(r_cnt);
        if (i_cmd.tw_cap_k) r_k <= w_rdata;
        if (i_cmd.tw_cap_n) r_n <= w_rdata;
        if (i_cmd.tw_cap_f) r_f <= w_rdata;
        if (i_cmd.dr_cap) r_temp <= w_t3 ^ (w_t3 >> 18);
        if (i_cmd.mul) r_prod <= {32'd0, r_temp} * {32'd0, i_range};
        if (i_cmd.out_load) r_res <= i_cmd.out_bounded ? r_prod[63:32] : r_temp;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_res;
    assign o_status.cnt_last       = (r_cnt == LAST);
    assign o_status.idx_empty      = (r_idx >= IW'(STATE_WORDS));
    assign o_status.never_seeded   = (r_idx == IW'(STATE_WORDS + 1));
    assign o_status.range_zero     = (i_range == 32'd0) | !i_use_bound;
    assign o_status.lo_below_range = (r_prod[31:0] < i_range);
    assign o_status.lo_below_t     = (r_prod[31:0] < w_mod_rem);
    assign o_status.mod_done       = w_mod_done;
    assign o_status.out_busy       = r_out_valid & !i_out_ready;
endmodule
`default_nettype wire

FILE: src/mtbg_ctrl.sv
// ----------------------------------------------------------------------------
// mtbg_ctrl
// Sequencer for seeding, twisting, drawing and rejection.
// ----------------------------------------------------------------------------
`default_nettype none
module mtbg_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_cmd,
    input  wire logic              i_use_bound,
    output logic                   o_in_ready,
    input  wire mtbg_pkg::t_status i_status,
    output mtbg_pkg::t_cmd         o_cmd,
    output logic                   o_idle
);
    mtbg_pkg::t_state r_state, n_state;
    logic r_dflt, n_dflt;   // seeding on behalf of a draw
    logic r_rej, n_rej;     // in rejection loop (t known)

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtbg_pkg::S_IDLE; r_dflt <= 1'b0; r_rej <= 1'b0;
        end else begin
            r_state <= n_state; r_dflt <= n_dflt; r_rej <= n_rej;
        end
    end

    assign o_in_ready = (r_state == mtbg_pkg::S_IDLE);
    assign o_idle     = o_in_ready;

    always_comb begin
        n_state = r_state; n_dflt = r_dflt; n_rej = r_rej;
        unique case (r_state)
            mtbg_pkg::S_IDLE: if (i_in_valid) begin
                n_dflt = 1'b0; n_rej = 1'b0;
                n_state = (i_in_cmd == mtbg_pkg::CMD_SEED) ? mtbg_pkg::S_SEED_W0
                                                           : mtbg_pkg::S_DR_RD;
            end
            mtbg_pkg::S_SEED_RD:  n_state = mtbg_pkg::S_SEED_W0;
            mtbg_pkg::S_SEED_W0:  n_state = mtbg_pkg::S_SEED_MUL;
            mtbg_pkg::S_SEED_MUL: n_state = mtbg_pkg::S_SEED_WR;
            mtbg_pkg::S_SEED_WR: begin
                if (!i_status.cnt_last) n_state = mtbg_pkg::S_SEED_MUL;
                else if (r_dflt) n_state = mtbg_pkg::S_TW_RD0;
                else n_state = mtbg_pkg::S_IDLE;
            end
            mtbg_pkg::S_TW_RD0:   n_state = mtbg_pkg::S_TW_RD1;
            mtbg_pkg::S_TW_RD1:   n_state = mtbg_pkg::S_TW_RD2;
            mtbg_pkg::S_TW_RD2:   n_state = mtbg_pkg::S_TW_LATCH;
            mtbg_pkg::S_TW_LATCH: n_state = mtbg_pkg::S_TW_WR;
            mtbg_pkg::S_TW_WR:
                n_state = i_status.cnt_last ? mtbg_pkg::S_DR_WAIT : mtbg_pkg::S_TW_RD0;
            mtbg_pkg::S_DR_RD: begin
                if (i_status.never_seeded) begin
                    n_dflt = 1'b1; n_state = mtbg_pkg::S_SEED_RD;
                end else if (i_status.idx_empty) n_state = mtbg_pkg::S_TW_RD0;
                else n_state = mtbg_pkg::S_DR_WAIT;
            end
            mtbg_pkg::S_DR_WAIT:  n_state = mtbg_pkg::S_DR_TEMP;
            mtbg_pkg::S_DR_TEMP:  n_state = i_use_bound ? mtbg_pkg::S_DR_MUL
                                                        : mtbg_pkg::S_OUT;
            mtbg_pkg::S_DR_MUL:   n_state = mtbg_pkg::S_DR_CHK;
            mtbg_pkg::S_DR_CHK: begin
                if (r_rej) n_state = i_status.lo_below_t ? mtbg_pkg::S_DR_RD
                                                         : mtbg_pkg::S_OUT;
                else if (!i_status.range_zero && i_status.lo_below_range)
                    n_state = mtbg_pkg::S_MOD_RUN;
                else n_state = mtbg_pkg::S_OUT;
            end
            mtbg_pkg::S_MOD_RUN: if (i_status.mod_done) begin
                n_rej = 1'b1; n_state = mtbg_pkg::S_DR_CHK2;
            end
            mtbg_pkg::S_DR_CHK2:
                n_state = i_status.lo_below_t ? mtbg_pkg::S_DR_RD : mtbg_pkg::S_OUT;
            mtbg_pkg::S_OUT: if (!i_status.out_busy) n_state = mtbg_pkg::S_IDLE;
            default: n_state = mtbg_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.rd_sel = 2'd0;
        unique case (r_state)
            mtbg_pkg::S_IDLE: if (i_in_valid && i_in_cmd == mtbg_pkg::CMD_SEED) begin
                o_cmd.load_seed = 1'b1; o_cmd.cnt_clr = 1'b1;
            end
            mtbg_pkg::S_SEED_RD: begin
                o_cmd.load_seed = 1'b1; o_cmd.use_default = 1'b1; o_cmd.cnt_clr = 1'b1;
            end
            // word 0 goes out, counter moves on to word 1
            mtbg_pkg::S_SEED_W0: begin
                o_cmd.seed_w0 = 1'b1; o_cmd.cnt_inc = 1'b1;
            end
            mtbg_pkg::S_SEED_MUL: o_cmd.seed_mul = 1'b1;
            mtbg_pkg::S_SEED_WR: begin
                o_cmd.seed_wr = 1'b1;
                if (i_status.cnt_last) begin
                    o_cmd.cnt_clr = 1'b1; o_cmd.idx_seeded = 1'b1;
                end else o_cmd.cnt_inc = 1'b1;
            end
            mtbg_pkg::S_TW_RD0: o_cmd.rd_sel = 2'd0;
            mtbg_pkg::S_TW_RD1: begin o_cmd.rd_sel = 2'd1; o_cmd.tw_cap_k = 1'b1; end
            mtbg_pkg::S_TW_RD2: begin o_cmd.rd_sel = 2'd2; o_cmd.tw_cap_n = 1'b1; end
            mtbg_pkg::S_TW_LATCH: o_cmd.tw_cap_f = 1'b1;
            mtbg_pkg::S_TW_WR: begin
                o_cmd.tw_wr = 1'b1;
                if (i_status.cnt_last) begin
                    o_cmd.cnt_clr = 1'b1; o_cmd.idx_zero = 1'b1;
                end else o_cmd.cnt_inc = 1'b1;
            end
            mtbg_pkg::S_DR_RD: begin
                o_cmd.rd_sel = 2'd3;
                if (i_status.idx_empty && !i_status.never_seeded) o_cmd.cnt_clr = 1'b1;
            end
            mtbg_pkg::S_DR_WAIT: o_cmd.rd_sel = 2'd3;
            mtbg_pkg::S_DR_TEMP: begin
                o_cmd.dr_cap = 1'b1; o_cmd.idx_inc = 1'b1;
            end
            mtbg_pkg::S_DR_MUL: o_cmd.mul = 1'b1;
            mtbg_pkg::S_DR_CHK:
                if (!r_rej && !i_status.range_zero && i_status.lo_below_range)
                    o_cmd.mod_start = 1'b1;
            mtbg_pkg::S_MOD_RUN: ;
            mtbg_pkg::S_DR_CHK2: ;
            mtbg_pkg::S_OUT: if (!i_status.out_busy) begin
                o_cmd.out_load = 1'b1; o_cmd.out_bounded = i_use_bound;
            end
            default: ;
        endcase
    end

    // a twist write happens only after the three reads of its word
    a_twist_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mtbg_pkg::S_TW_WR) |-> $past(r_state == mtbg_pkg::S_TW_LATCH))
        else $error("twist write out of order");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != mtbg_pkg::S_IDLE) |-> !o_in_ready)
        else $error("ready while busy");
    a_out_only_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (r_state == mtbg_pkg::S_OUT))
        else $error("result loaded outside output step");
endmodule
`default_nettype wire

FILE: src/mt19937_bounded_generator_core.sv
// ----------------------------------------------------------------------------
// mt19937_bounded_generator_core
// MT19937 generator with seed and draw commands and bounded draw mode.
// ----------------------------------------------------------------------------
// One item at a time. A seed command writes all 624 state words and gives no
// result. A draw reads one word from the single-port state RAM and tempers
// it. Every 624th word first runs the twist through the one RAM port, with
// three reads and a write per word. A bounded draw whose low product half
// falls below the range adds a remainder step and redraws on rejection.
// A first draw without seed seeds with 5489 first. Results wait in an
// output register; the next command is taken once it is loaded.
// Config (index 0 use_bound, index 1 bound_range) is taken at any time.
`default_nettype none
module mt19937_bounded_generator_core #(
    parameter int STATE_WORDS = mtbg_pkg::STATE_WORDS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mtbg_if.sink      in_ch,   // data = {seed_value, command}
    mtbg_if.source    out_ch,  // data = value
    mtbg_if.sink      cfg_ch   // data = {write data[31:0], index}
);
    logic        r_use_bound;
    logic [31:0] r_range;
    mtbg_pkg::t_cmd    w_cmd;
    mtbg_pkg::t_status w_status;
    logic w_idle;

    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_bound <= 1'b0; r_range <= '0;
        end else if (cfg_ch.valid) begin
            if (cfg_ch.data[0] == mtbg_pkg::REG_USE_BOUND) r_use_bound <= cfg_ch.data[1];
            else if (cfg_ch.data[0] == mtbg_pkg::REG_BOUND_RANGE)
                r_range <= cfg_ch.data[32:1];
        end
    end

    mtbg_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(in_ch.valid),
        .i_in_cmd(in_ch.data[0]), .i_use_bound(r_use_bound), .o_in_ready(in_ch.ready),
        .i_status(w_status), .o_cmd(w_cmd), .o_idle(w_idle)
    );

    mtbg_datapath #(.STATE_WORDS(STATE_WORDS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_seed(in_ch.data[32:1]),
        .i_use_bound(r_use_bound), .i_range(r_range), .i_out_ready(out_ch.ready),
        .o_out_valid(out_ch.valid), .o_out_value(out_ch.data), .o_status(w_status)
    );

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_idle |-> in_ch.ready) else $error("idle mismatch");
endmodule
`default_nettype wire
